// File: design/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

	// Field widths of a transaction.
	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int SLOT_W = 5;

	typedef logic [IP_W-1:0]   ip_t;
	typedef logic [MAC_W-1:0]  mac_t;
	typedef logic [SLOT_W-1:0] slot_t;

	// Operation codes.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

endpackage

`default_nettype wire

// File: design/arp_cache_table_core.sv
// Address resolution table: maps IPv4 addresses to MAC addresses.
// Input channel (in_valid / in_stall) carries op, ip_addr and mac_in. A lookup
// (op = 0) returns hit, slot and the stored MAC; an update (op = 1) refreshes a
// matching entry or fills the lowest free slot, slot 0 when the table is full.
// Output channel (out_valid / out_stall) carries exactly one result per item.
// Entries are written in fill order and never freed, so a fill count stands in
// for per-entry valid bits. Addresses and MACs live in two synchronous memories
// with a registered read port.
// One item at a time: the block scans entries 0 up to the fill count, one memory
// read per cycle, compares each entry in the cycle after its read, and stops at
// the first match. The result then goes to a result register.
// The result sits in an output register; the next item is accepted as soon as the
// previous result has been moved there, even while the receiver stalls it.
// Reset clears the fill count, so every entry reads as empty, and drops any
// pending result. No clearing pass is needed.
`default_nettype none

module arp_cache_table_core
	import arpc_pkg::*;
#(
	parameter int ENTRIES = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire logic  op,
	input  wire ip_t   ip_addr,
	input  wire mac_t  mac_in,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic       hit,
	output slot_t      slot,
	output mac_t       mac_out
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// Entry storage.
	ip_t  ip_mem  [ENTRIES];
	mac_t mac_mem [ENTRIES];

	logic [1:0]    state_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] scan_q;
	logic          op_q;
	ip_t           ip_q;
	mac_t          mac_q;

	logic          chk_s1;
	logic [AW-1:0] chk_addr_s1;
	ip_t           rd_ip_s1;
	mac_t          rd_mac_s1;

	logic  res_hit_q;
	slot_t res_slot_q;
	mac_t  res_mac_q;

	logic  out_valid_q;
	logic  hit_q;
	slot_t slot_q;
	mac_t  mac_out_q;

	logic          in_acc;
	logic          rd_en;
	logic          match;
	logic          scan_end;
	logic          full;
	logic          resolve;
	logic          ip_we;
	logic          mac_we;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] free_addr;
	logic [AW+SLOT_W-1:0] match_ext;
	logic [AW+SLOT_W-1:0] free_ext;
	logic          out_load;

	// Handshake decode.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Scan control: issue reads below the fill count, compare in the cycle after.
	assign rd_en    = (state_q == ST_SCAN) && (scan_q < fill_q) && !match;
	assign match    = (state_q == ST_SCAN) && chk_s1 && (rd_ip_s1 == ip_q);
	assign scan_end = (state_q == ST_SCAN) && !chk_s1 && (scan_q == fill_q);
	assign resolve  = match || scan_end;
	assign full     = (fill_q == ENT_C);

	// Write address: the matched entry, else the lowest free one, else slot 0.
	assign free_addr = full ? '0 : fill_q[AW-1:0];
	assign wr_addr   = match ? chk_addr_s1 : free_addr;
	assign mac_we    = resolve && (op_q == OP_UPDATE);
	assign ip_we     = scan_end && (op_q == OP_UPDATE);
	assign match_ext = {{SLOT_W{1'b0}}, chk_addr_s1};
	assign free_ext  = {{SLOT_W{1'b0}}, free_addr};

	// Address memory.
	always_ff @(posedge clk) begin
		if (ip_we) begin
			ip_mem[wr_addr] <= ip_q;
		end
		if (rd_en) begin
			rd_ip_s1 <= ip_mem[scan_q[AW-1:0]];
		end
	end

	// MAC memory.
	always_ff @(posedge clk) begin
		if (mac_we) begin
			mac_mem[wr_addr] <= mac_q;
		end
		if (rd_en) begin
			rd_mac_s1 <= mac_mem[scan_q[AW-1:0]];
		end
	end

	// Sequencer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			scan_q  <= '0;
			chk_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
						chk_s1  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (resolve) begin
						state_q <= ST_DONE;
						chk_s1  <= 1'b0;
						if (ip_we && !full) begin
							fill_q <= CW'(fill_q + 1'b1);
						end
					end else begin
						chk_s1 <= rd_en;
						if (rd_en) begin
							scan_q <= CW'(scan_q + 1'b1);
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and scan address registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= op;
			ip_q  <= ip_addr;
			mac_q <= mac_in;
		end
		if (rd_en && !resolve) begin
			chk_addr_s1 <= scan_q[AW-1:0];
		end
	end

	// Result of the finished item.
	always_ff @(posedge clk) begin
		if (resolve) begin
			if (match) begin
				res_hit_q  <= 1'b1;
				res_slot_q <= match_ext[SLOT_W-1:0];
				res_mac_q  <= (op_q == OP_UPDATE) ? mac_q : rd_mac_s1;
			end else if (op_q == OP_UPDATE) begin
				res_hit_q  <= 1'b0;
				res_slot_q <= free_ext[SLOT_W-1:0];
				res_mac_q  <= mac_q;
			end else begin
				res_hit_q  <= 1'b0;
				res_slot_q <= '0;
				res_mac_q  <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q     <= res_hit_q;
			slot_q    <= res_slot_q;
			mac_out_q <= res_mac_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign slot      = slot_q;
	assign mac_out   = mac_out_q;

	// The fill count never passes the table size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ENT_C)
		else $error("fill count exceeds table size");

	// The fill count grows by at most one entry per cycle and never shrinks.
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (fill_q == $past(fill_q)) || (fill_q == CW'($past(fill_q) + 1'b1)))
		else $error("fill count changed by more than one");

	// A compared entry always lies below the fill count.
	a_chk_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && chk_s1) |-> (CW'(chk_addr_s1) < fill_q))
		else $error("compared an entry that was never written");

	// A result moved to the output register is shown in the next cycle.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("loaded result not shown");

endmodule

`default_nettype wire

// File: tb/arp_cache_table_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the address resolution table, keeps a shadow copy
// of the table, and compares every result transaction with its prediction.
module arp_cache_table_checker
	import arpc_pkg::*;
#(
	parameter int ENTRIES = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_stall,
	input  wire logic op,
	input  wire ip_t  ip_addr,
	input  wire mac_t mac_in,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire logic hit,
	input  wire slot_t slot,
	input  wire mac_t mac_out,
	output int        fail_count,
	output int        results_pending
);

	typedef struct packed {
		logic  hit;
		slot_t slot;
		mac_t  mac;
	} arp_result_t;

	// Shadow table: one used flag, address and MAC per slot.
	logic shadow_used [ENTRIES];
	ip_t  shadow_ip   [ENTRIES];
	mac_t shadow_mac  [ENTRIES];

	// Results predicted for accepted requests, oldest first.
	arp_result_t awaited_results [$];

	initial begin
		fail_count      = 0;
		results_pending = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Applies one request to the shadow table and returns the result it must give.
	function automatic arp_result_t resolve_request(input logic op_i, input ip_t ip_i,
			input mac_t mac_i);
		int match_idx;
		int free_idx;
		arp_result_t res;
		match_idx = -1;
		free_idx  = -1;
		res       = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_idx < 0 && shadow_used[i] && shadow_ip[i] == ip_i)
				match_idx = i;
			if (free_idx < 0 && !shadow_used[i])
				free_idx = i;
		end
		if (op_i == OP_LOOKUP) begin
			if (match_idx >= 0) begin
				res.hit  = 1'b1;
				res.slot = slot_t'(match_idx);
				res.mac  = shadow_mac[match_idx];
			end
		end else if (match_idx >= 0) begin
			// A known address only gets its MAC refreshed.
			shadow_mac[match_idx] = mac_i;
			res.hit  = 1'b1;
			res.slot = slot_t'(match_idx);
			res.mac  = mac_i;
		end else begin
			// A new address takes the lowest free slot, or slot 0 on a full table.
			if (free_idx < 0)
				free_idx = 0;
			shadow_used[free_idx] = 1'b1;
			shadow_ip[free_idx]   = ip_i;
			shadow_mac[free_idx]  = mac_i;
			res.slot = slot_t'(free_idx);
			res.mac  = mac_i;
		end
		return res;
	endfunction

	// Results are checked before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		arp_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				shadow_used[i] = 1'b0;
			awaited_results.delete();
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result transaction with nothing awaited"));
				end else begin
					want = awaited_results.pop_front();
					if (hit !== want.hit)
						report_mismatch($sformatf("hit got %b expected %b", hit, want.hit));
					if (slot !== want.slot)
						report_mismatch($sformatf("slot got %0d expected %0d", slot,
							want.slot));
					if (mac_out !== want.mac)
						report_mismatch($sformatf("mac_out got %h expected %h", mac_out,
							want.mac));
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				awaited_results.push_back(resolve_request(op, ip_addr, mac_in));
		end
		results_pending = awaited_results.size();
	end

endmodule

// File: tb/tb_arp_cache_table_core.sv
`timescale 1ns / 100ps

module tb_arp_cache_table_core;
	import arpc_pkg::*;

	localparam int ENTRIES     = 32;
	localparam int RANDOM_REQS = 1835;
	localparam int TAIL_REQS   = 150;
	localparam int POOL_SIZE   = 40;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	logic  in_stall;
	logic  op        = OP_LOOKUP;
	ip_t   ip_addr   = '0;
	mac_t  mac_in    = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	logic  hit;
	slot_t slot;
	mac_t  mac_out;

	int fail_count;
	int results_pending;

	int requests_sent = 0;
	bit tail_phase    = 1'b0;
	int send_calm     = 0;
	ip_t addr_pool [POOL_SIZE];

	always #6 clk = ~clk;

	arp_cache_table_core #(
		.ENTRIES(ENTRIES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.ip_addr  (ip_addr),
		.mac_in   (mac_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit      (hit),
		.slot     (slot),
		.mac_out  (mac_out)
	);

	arp_cache_table_checker #(
		.ENTRIES(ENTRIES)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.ip_addr        (ip_addr),
		.mac_in         (mac_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.slot           (slot),
		.mac_out        (mac_out),
		.fail_count     (fail_count),
		.results_pending(results_pending)
	);

	// Offers one request transaction, after an optional idle burst, and waits
	// until the block takes it.
	task automatic send_request(input logic op_i, input ip_t ip_i, input mac_t mac_i);
		int gap;
		gap = 0;
		if (!tail_phase && send_calm == 0 && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 9);
		if (send_calm > 0)
			send_calm--;
		else if ($urandom_range(0, 60) == 0)
			send_calm = $urandom_range(10, 40);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= op_i;
		ip_addr  <= ip_i;
		mac_in   <= mac_i;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		requests_sent++;
	endtask

	// Receiver side: random stall bursts, quiet stretches, and one long hold-off
	// that backs the block up into its input.
	initial begin
		int  burst_left;
		int  calm_left;
		int  hold_left;
		bit  hold_done;
		logic stall_next;
		burst_left = 0;
		calm_left  = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!hold_done && requests_sent >= 200) begin
				hold_done  = 1'b1;
				hold_left  = 299;
				stall_next = 1'b1;
			end else if (tail_phase) begin
				stall_next = 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				stall_next = 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
				stall_next = 1'b0;
			end else if ($urandom_range(0, 60) == 0) begin
				calm_left  = $urandom_range(20, 80);
				stall_next = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 9) - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			out_stall <= stall_next;
		end
	end

	// Stimulus: directed corner cases, then random traffic over a small address pool
	// so that the table fills, stays full and keeps getting hits on deep slots.
	initial begin
		int   guard;
		logic op_r;
		ip_t  ip_r;
		mac_t mac_r;
		int   pick;

		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;
		addr_pool[2] = 32'h8000_0000;
		addr_pool[3] = 32'h0000_0001;
		for (int i = 4; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Lookups on an empty table miss, whatever the MAC field holds.
		send_request(OP_LOOKUP, 32'h0000_0000, 48'h0);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		// Inserts at the address and MAC extremes.
		send_request(OP_UPDATE, 32'h0000_0000, 48'h0);
		send_request(OP_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_request(OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
		// Updates of known addresses only refresh the MAC.
		send_request(OP_UPDATE, 32'h0000_0000, 48'hAAAA_AAAA_AAAA);
		send_request(OP_UPDATE, 32'hFFFF_FFFF, 48'h5555_5555_5555);
		send_request(OP_LOOKUP, 32'h0000_0000, 48'h1234_5678_9ABC);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
		send_request(OP_UPDATE, 32'h8000_0000, 48'h8000_0000_0000);
		send_request(OP_UPDATE, 32'h0000_0001, 48'h0000_0000_0001);
		// Near misses must not match; the inserted 32'h0000_0001 must hit.
		send_request(OP_LOOKUP, 32'h8000_0001, 48'h0);
		send_request(OP_LOOKUP, 32'h0000_0001, 48'h0);
		send_request(OP_LOOKUP, 32'h7FFF_FFFF, 48'h0);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n >= RANDOM_REQS - TAIL_REQS)
				tail_phase = 1'b1;
			op_r = $urandom_range(0, 1) ? OP_UPDATE : OP_LOOKUP;
			if ($urandom_range(0, 99) < 85)
				ip_r = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				ip_r = $urandom;
			pick = $urandom_range(0, 15);
			if (pick == 0)
				mac_r = '0;
			else if (pick == 1)
				mac_r = '1;
			else
				mac_r = mac_t'({$urandom, $urandom});
			send_request(op_r, ip_r, mac_r);
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain: wait for every awaited result, then let the clock run on before the verdict.
		guard = 0;
		while (results_pending != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		if (results_pending != 0) begin
			$display("FAIL");
			$finish;
		end else begin
			repeat (ENTRIES + 8) @(negedge clk);
			if (fail_count == 0 && results_pending == 0)
				$display("PASS");
			else
				$display("FAIL");
			$finish;
		end
	end

	// Hard limit on the whole run.
	initial begin
		#12_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
